// ===== hdl/b64_pkg.sv =====
package b64_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int unsigned GROUP_MAX = 4;
  localparam int unsigned CNT_W     = 3;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
  localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
  localparam logic [5:0] VAL_PLUS       = 6'd62;
  localparam logic [5:0] VAL_SLASH      = 6'd63;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       bad;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    result_t [GROUP_MAX-1:0]    res;
  } group_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } dec_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < VAL_LOWER_BASE) begin
      c = CH_UPPER_A + {2'b00, v};
    end else if (v < VAL_DIGIT_BASE) begin
      c = CH_LOWER_A + {2'b00, v - VAL_LOWER_BASE};
    end else if (v < VAL_PLUS) begin
      c = CH_DIGIT_0 + {2'b00, v - VAL_DIGIT_BASE};
    end else if (v == VAL_PLUS) begin
      c = CH_PLUS;
    end else begin
      c = CH_SLASH;
    end
    return c;
  endfunction

  function automatic dec_t dec_char(input logic [7:0] c);
    dec_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d.val = 6'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d.val = 6'(c - CH_LOWER_A) + VAL_LOWER_BASE;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d.val = 6'(c - CH_DIGIT_0) + VAL_DIGIT_BASE;
    end else if (c == CH_PLUS) begin
      d.val = VAL_PLUS;
    end else if (c == CH_SLASH) begin
      d.val = VAL_SLASH;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== hdl/b64_core.sv =====
module b64_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mode,
  input  logic            clear,
  input  logic            advance,
  input  logic [7:0]      item_data,
  input  logic            item_last,
  output b64_pkg::group_t grp
);
  import b64_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [5:0] carry_r, carry_nxt;

  always_comb begin
    group_t     g;
    dec_t       d;
    logic [1:0] p;
    logic [5:0] cy;
    g  = '0;
    d  = dec_char(item_data);
    p  = pos_r;
    cy = carry_r;
    if (mode == MODE_ENCODE) begin
      unique case (pos_r)
        2'd1: begin
          g.res[0] = '{data: enc_char({carry_r[1:0], item_data[7:4]}), valid: 1'b1,
                       last: 1'b0, bad: 1'b0};
          g.cnt = 3'd1;
          cy = {2'b00, item_data[3:0]};
          p  = 2'd2;
          if (item_last) begin
            g.res[1] = '{data: enc_char({item_data[3:0], 2'b00}), valid: 1'b1,
                         last: 1'b0, bad: 1'b0};
            g.res[2] = '{data: CH_PAD, valid: 1'b1, last: 1'b0, bad: 1'b0};
            g.cnt = 3'd3;
          end
        end
        2'd2: begin
          g.res[0] = '{data: enc_char({carry_r[3:0], item_data[7:6]}), valid: 1'b1,
                       last: 1'b0, bad: 1'b0};
          g.res[1] = '{data: enc_char(item_data[5:0]), valid: 1'b1,
                       last: 1'b0, bad: 1'b0};
          g.cnt = 3'd2;
          cy = '0;
          p  = 2'd0;
        end
        default: begin
          g.res[0] = '{data: enc_char(item_data[7:2]), valid: 1'b1,
                       last: 1'b0, bad: 1'b0};
          g.cnt = 3'd1;
          cy = {4'b0000, item_data[1:0]};
          p  = 2'd1;
          if (item_last) begin
            g.res[1] = '{data: enc_char({item_data[1:0], 4'b0000}), valid: 1'b1,
                         last: 1'b0, bad: 1'b0};
            g.res[2] = '{data: CH_PAD, valid: 1'b1, last: 1'b0, bad: 1'b0};
            g.res[3] = '{data: CH_PAD, valid: 1'b1, last: 1'b0, bad: 1'b0};
            g.cnt = 3'd4;
          end
        end
      endcase
    end else begin
      if (!d.ok) begin
        // skip pad and line breaks; anything else is flagged, state holds
        if (!(item_data == CH_PAD || item_data == CH_LF || item_data == CH_CR)) begin
          g.res[0] = '{data: 8'h00, valid: 1'b0, last: 1'b0, bad: 1'b1};
          g.cnt = 3'd1;
        end
      end else begin
        unique case (pos_r)
          2'd0: begin
            cy = d.val;
            p  = 2'd1;
          end
          2'd1: begin
            g.res[0] = '{data: {carry_r, d.val[5:4]}, valid: 1'b1, last: 1'b0, bad: 1'b0};
            g.cnt = 3'd1;
            cy = {2'b00, d.val[3:0]};
            p  = 2'd2;
          end
          2'd2: begin
            g.res[0] = '{data: {carry_r[3:0], d.val[5:2]}, valid: 1'b1,
                         last: 1'b0, bad: 1'b0};
            g.cnt = 3'd1;
            cy = {4'b0000, d.val[1:0]};
            p  = 2'd3;
          end
          default: begin
            g.res[0] = '{data: {carry_r[1:0], d.val}, valid: 1'b1, last: 1'b0, bad: 1'b0};
            g.cnt = 3'd1;
            cy = '0;
            p  = 2'd0;
          end
        endcase
      end
      if (item_last && g.cnt == '0) begin
        g.res[0] = '{data: 8'h00, valid: 1'b0, last: 1'b0, bad: 1'b0};
        g.cnt = 3'd1;
      end
    end
    if (item_last) begin
      for (int i = 0; i < GROUP_MAX; i++) begin
        g.res[i].last = (CNT_W'(i) == g.cnt - 3'd1);
      end
      p  = '0;
      cy = '0;
    end
    grp       = g;
    pos_nxt   = p;
    carry_nxt = cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pos_r   <= '0;
      carry_r <= '0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// ===== hdl/b64_outq.sv =====
module b64_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  b64_pkg::group_t  grp,
  input  logic             take,
  output logic             space,
  output logic             q_valid,
  output b64_pkg::result_t q_head
);
  import b64_pkg::*;

  result_t [GROUP_MAX-1:0] res_r;
  logic [CNT_W-1:0]        cnt_r;

  assign q_valid = (cnt_r != '0);
  assign q_head  = res_r[0];
  // room for a new group once the last queued beat leaves
  assign space   = (cnt_r == '0) || (cnt_r == CNT_W'(1) && take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= grp.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= grp.res;
    end else if (take) begin
      for (int i = 0; i < GROUP_MAX - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

endmodule

// ===== hdl/base64_stream_codec.sv =====
// Base64 stream codec, standard alphabet.
// cfg_we/cfg_wdata write the mode (0 encode, 1 decode); every write also
// restarts the group. Write only while no beat is in flight.
// Input channel in_valid/in_ready carries one byte or character per beat
// with in_last_in closing the message. Output channel out_valid/out_ready
// carries result beats: data, data_valid, last_out and bad_char.
// The first result of an input beat passes through the input register,
// then the result buffer, before the output presents it.
// Throughput: one input beat per cycle while each beat yields at most one
// result and the receiver is ready; a beat with more results holds the
// input, since the result buffer drains one beat per cycle while out_ready
// is high.
// Reset (rst_n low, synchronous) empties both registers and selects encode.
// A stalled receiver holds the result buffer; one further input beat waits
// in the input register, then in_ready drops until the buffer frees.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_in,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_out,
  output logic       out_data_valid,
  output logic       out_last_out,
  output logic       out_bad_char
);
  import b64_pkg::*;

  logic       mode_r;
  logic       item_vld_r;
  logic [7:0] item_data_r;
  logic       item_last_r;

  group_t  grp;
  result_t head;
  logic    space;
  logic    take;
  logic    advance;
  logic    load;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // an item with no results retires at once; otherwise it waits for buffer room
  assign take     = out_valid && out_ready;
  assign advance  = item_vld_r && ((grp.cnt == '0) || space);
  assign load     = advance && (grp.cnt != '0);
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  // hold the payload of the pending beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_data_r <= in_data_in;
      item_last_r <= in_last_in;
    end
  end

  b64_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .clear     (cfg_we),
    .advance   (advance),
    .item_data (item_data_r),
    .item_last (item_last_r),
    .grp       (grp)
  );

  b64_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .grp     (grp),
    .take    (take),
    .space   (space),
    .q_valid (out_valid),
    .q_head  (head)
  );

  assign out_data_out   = head.data;
  assign out_data_valid = head.valid;
  assign out_last_out   = head.last;
  assign out_bad_char   = head.bad;

endmodule
